[design/nfa_string_recognizer_assert.svh]
// Assertion macros for the recognizer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef NFA_STRING_RECOGNIZER_ASSERT_SVH
`define NFA_STRING_RECOGNIZER_ASSERT_SVH

// Plain property that must hold on every clock edge outside of reset.
`define NFASR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nfasr assertion failed");

// Condition in one cycle implies a consequence in the following cycle.
`define NFASR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("nfasr assertion failed");

`endif

[design/nfasr_pkg.sv]
// Shared types and constants of the NFA string recognizer.
// No dependencies; used by every module of the block.
package nfasr_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned SET_W   = 16;
  localparam int unsigned CFG_W   = 5;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_FEED  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [STATE_W-1:0]   from_state;
    logic [SLOT_W-1:0]    slot_index;
    logic                 slot_valid;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   to_state;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 alive;
    logic [SET_W-1:0]     active_set;
  } out_item_t;

  // Write request from the control stage to the transition table.
  typedef struct packed {
    logic                 we;
    logic [STATE_W-1:0]   from_state;
    logic [SLOT_W-1:0]    slot_index;
    logic                 enable;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   to_state;
  } load_req_t;

endpackage

[design/nfasr_slot_table.sv]
// Transition slot storage and per-slot symbol match.
// Depends on nfasr_pkg for the load request type and field widths.
module nfasr_slot_table #(
  parameter int unsigned MAX_STATES      = 16,
  parameter int unsigned SLOTS_PER_STATE = 4
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  nfasr_pkg::load_req_t                            req_i,
  input  logic [nfasr_pkg::SYM_W-1:0]                     feed_sym_i,
  output logic [MAX_STATES*SLOTS_PER_STATE-1:0]           hit_o,
  output logic [MAX_STATES*SLOTS_PER_STATE-1:0][nfasr_pkg::STATE_W-1:0] tgt_o
);

  localparam int unsigned SlotCount = MAX_STATES * SLOTS_PER_STATE;

  logic [SlotCount-1:0]                          en_q;
  logic [SlotCount-1:0]                          we;
  logic [SlotCount-1:0][nfasr_pkg::SYM_W-1:0]    sym_q;
  logic [SlotCount-1:0][nfasr_pkg::STATE_W-1:0]  tgt_q;

  // Loads that name a state or slot beyond the table match no entry.
  always_comb begin
    for (int k = 0; k < SlotCount; k++) begin
      we[k] = req_i.we &&
              (32'(req_i.from_state) == k / SLOTS_PER_STATE) &&
              (32'(req_i.slot_index) == k % SLOTS_PER_STATE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else begin
      for (int k = 0; k < SlotCount; k++) begin
        if (we[k]) begin
          en_q[k] <= req_i.enable;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SlotCount; k++) begin
      if (we[k]) begin
        sym_q[k] <= req_i.symbol;
        tgt_q[k] <= req_i.to_state;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < SlotCount; k++) begin
      hit_o[k] = en_q[k] && (sym_q[k] == feed_sym_i);
    end
  end

  assign tgt_o = tgt_q;

endmodule

[design/nfasr_next_state.sv]
// Bit-parallel NFA step: union of the in-use targets of the matching slots of active states.
// Depends on nfasr_pkg for the state field width.
module nfasr_next_state #(
  parameter int unsigned MAX_STATES      = 16,
  parameter int unsigned SLOTS_PER_STATE = 4
) (
  input  logic [MAX_STATES-1:0]                                          active_i,
  input  logic [$clog2(MAX_STATES+1)-1:0]                                used_i,
  input  logic [MAX_STATES*SLOTS_PER_STATE-1:0]                          hit_i,
  input  logic [MAX_STATES*SLOTS_PER_STATE-1:0][nfasr_pkg::STATE_W-1:0]  tgt_i,
  output logic [MAX_STATES-1:0]                                          next_o
);

  localparam int unsigned SlotCount = MAX_STATES * SLOTS_PER_STATE;

  logic [SlotCount-1:0] live;

  // A slot fires only if its owner is active and inside the states in use.
  always_comb begin
    for (int k = 0; k < SlotCount; k++) begin
      live[k] = hit_i[k] && active_i[k / SLOTS_PER_STATE] &&
                ((k / SLOTS_PER_STATE) < 32'(used_i));
    end
  end

  always_comb begin
    next_o = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      for (int k = 0; k < SlotCount; k++) begin
        if (live[k] && (32'(tgt_i[k]) == i) && (i < 32'(used_i))) begin
          next_o[i] = 1'b1;
        end
      end
    end
  end

endmodule

[design/nfa_string_recognizer.sv]
// NFA string recognizer: an input register, combinational bit-parallel next-state
// logic over all transition slots, and a result register. One item is taken every
// clock cycle while the result register is not held full by the receiver. A start
// or feed item moves from the input register into the result register once that
// register is free; a load shows no result. The rate rests on the active-set
// register, which feeds the combinational match and union logic across all
// MAX_STATES * SLOTS_PER_STATE slots and is written back at the edge that moves
// the item on. Loads and register writes take effect for the next feed item.
// Depends on nfasr_pkg, nfasr_slot_table, nfasr_next_state and the assert header.
`include "nfa_string_recognizer_assert.svh"

module nfa_string_recognizer #(
  parameter int unsigned MAX_STATES      = 16,
  parameter int unsigned SLOTS_PER_STATE = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nfasr_pkg::in_item_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nfasr_pkg::out_item_t          out_item_o,
  input  logic                          cfg_we_i,
  input  logic [nfasr_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned SlotCount = MAX_STATES * SLOTS_PER_STATE;
  localparam int unsigned UsedW     = $clog2(MAX_STATES + 1);
  localparam int unsigned ShowW     = (MAX_STATES < nfasr_pkg::SET_W) ?
                                      MAX_STATES : nfasr_pkg::SET_W;
  localparam logic [nfasr_pkg::SET_W-1:0] StartSet = nfasr_pkg::SET_W'(1);

  logic [nfasr_pkg::CFG_W-1:0]  cfg_q;
  logic                         s1_valid_q, s1_valid_d;
  nfasr_pkg::in_item_t          s1_item_q;
  logic                         out_valid_q, out_valid_d;
  nfasr_pkg::out_item_t         out_q, out_d;
  logic [MAX_STATES-1:0]        active_q, active_d;
  logic [UsedW-1:0]             used;
  logic                         produces, out_free, advance, in_fire;
  logic                         adv_start, adv_feed;
  nfasr_pkg::load_req_t         load_req;
  logic [SlotCount-1:0]         hit;
  logic [SlotCount-1:0][nfasr_pkg::STATE_W-1:0] tgt;
  logic [MAX_STATES-1:0]        next_set;
  logic                         accept_bit;

  // Clamp the state count into 1 .. MAX_STATES.
  always_comb begin
    if (cfg_q == '0) begin
      used = UsedW'(1);
    end else if (32'(cfg_q) > MAX_STATES) begin
      used = UsedW'(MAX_STATES);
    end else begin
      used = UsedW'(cfg_q);
    end
  end

  assign produces = (s1_item_q.cmd == nfasr_pkg::CMD_START) ||
                    (s1_item_q.cmd == nfasr_pkg::CMD_FEED);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = s1_valid_q && (!produces || out_free);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire  = in_valid_i && in_ready_o;
  assign adv_start = advance && (s1_item_q.cmd == nfasr_pkg::CMD_START);
  assign adv_feed  = advance && (s1_item_q.cmd == nfasr_pkg::CMD_FEED);

  always_comb begin
    load_req.we         = advance && (s1_item_q.cmd == nfasr_pkg::CMD_LOAD);
    load_req.from_state = s1_item_q.from_state;
    load_req.slot_index = s1_item_q.slot_index;
    load_req.enable     = s1_item_q.slot_valid;
    load_req.symbol     = s1_item_q.symbol;
    load_req.to_state   = s1_item_q.to_state;
  end

  nfasr_slot_table #(
    .MAX_STATES      (MAX_STATES),
    .SLOTS_PER_STATE (SLOTS_PER_STATE)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (load_req),
    .feed_sym_i (s1_item_q.symbol),
    .hit_o      (hit),
    .tgt_o      (tgt)
  );

  nfasr_next_state #(
    .MAX_STATES      (MAX_STATES),
    .SLOTS_PER_STATE (SLOTS_PER_STATE)
  ) u_step (
    .active_i (active_q),
    .used_i   (used),
    .hit_i    (hit),
    .tgt_i    (tgt),
    .next_o   (next_set)
  );

  always_comb begin
    active_d = active_q;
    if (advance) begin
      case (s1_item_q.cmd)
        nfasr_pkg::CMD_START: active_d = MAX_STATES'(1);
        nfasr_pkg::CMD_FEED:  active_d = next_set;
        default:              active_d = active_q;
      endcase
    end
  end

  // The accepting state is the last one in use.
  always_comb begin
    accept_bit = 1'b0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (32'(used) == i + 1) begin
        accept_bit = active_d[i];
      end
    end
  end

  always_comb begin
    out_d.accepted   = accept_bit;
    out_d.alive      = |active_d;
    out_d.active_set = nfasr_pkg::SET_W'(active_d[ShowW-1:0]);
  end

  assign s1_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = (advance && produces) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= nfasr_pkg::CFG_W'(1);
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= MAX_STATES'(1);
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (advance && produces) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The input side only stalls behind a full result register.
  `NFASR_ASSERT(a_ready_only_blocked, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
  // A start always reports state zero as the only active state.
  `NFASR_ASSERT_NEXT(a_start_result, adv_start, out_valid_q && (out_q.active_set == StartSet))
  // The reported liveness matches the stored active set.
  `NFASR_ASSERT_NEXT(a_alive_matches, adv_feed, out_q.alive == (active_q != '0))

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the NFA string recognizer: random and directed traffic
// on the item channels and the states-in-use register. Depends on nfasr_pkg and the RTL.

module tb_top;
  import nfasr_pkg::*;

  localparam int unsigned NSTATES = 16;
  localparam int unsigned NSLOTS  = 4;
  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned HOLD_CYCLES = 300;

  // Tracks the automaton state and queues the verdicts the block must produce.
  class nfa_tracker;
    logic [SET_W-1:0]   active;
    logic [SYM_W-1:0]   slot_sym [NSTATES*NSLOTS];
    logic [STATE_W-1:0] slot_tgt [NSTATES*NSLOTS];
    bit                 slot_en  [NSTATES*NSLOTS];
    logic [CFG_W-1:0]   states_reg;
    out_item_t          verdicts [$];
    int                 errors;
    int                 checked;

    function new();
      active = SET_W'(1);
      states_reg = CFG_W'(1);
      errors = 0;
      checked = 0;
      foreach (slot_en[k]) begin
        slot_en[k] = 1'b0;
        slot_sym[k] = '0;
        slot_tgt[k] = '0;
      end
    endfunction

    function int unsigned used_states();
      if (states_reg < 1) return 1;
      if (states_reg > NSTATES) return NSTATES;
      return 32'(states_reg);
    endfunction

    function void set_states(logic [CFG_W-1:0] v);
      states_reg = v;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function out_item_t verdict();
      out_item_t v;
      v.accepted   = active[used_states() - 1];
      v.alive      = (active != '0);
      v.active_set = active;
      return v;
    endfunction

    function void note_item(in_item_t it);
      int unsigned n;
      int k;
      logic [SET_W-1:0] nxt;
      n = used_states();
      nxt = '0;
      case (it.cmd)
        CMD_LOAD: begin
          k = it.from_state * NSLOTS + it.slot_index;
          slot_sym[k] = it.symbol;
          slot_tgt[k] = it.to_state;
          slot_en[k]  = it.slot_valid;
        end
        CMD_START: begin
          active = SET_W'(1);
          verdicts.push_back(verdict());
        end
        CMD_FEED: begin
          // States outside the range in use fire no slots and drop out of the set.
          for (int s = 0; s < n; s++) begin
            if (active[s]) begin
              for (int j = 0; j < NSLOTS; j++) begin
                k = s * NSLOTS + j;
                if (slot_en[k] && slot_sym[k] == it.symbol && slot_tgt[k] < n)
                  nxt[slot_tgt[k]] = 1'b1;
              end
            end
          end
          active = nxt;
          verdicts.push_back(verdict());
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (verdicts.size() == 0) begin
        $error("unexpected result: active_set %h", got.active_set);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      checked++;
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.alive !== want.alive) begin
        $error("alive: expected %0d, got %0d", want.alive, got.alive);
        errors++;
      end
      if (got.active_set !== want.active_set) begin
        $error("active_set: expected %h, got %h", want.active_set, got.active_set);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  nfa_tracker sb;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int cfg_writes = 0;

  nfa_string_recognizer #(
    .MAX_STATES      (NSTATES),
    .SLOTS_PER_STATE (NSLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results still outstanding.", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Receiver: random stalls, one long hold-off so the block backs up into its input, none when quiet.
  initial begin : rx_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] c, int f, int s, bit v, int sym, int to);
    in_item_t it;
    it.cmd        = cmd_e'(c);
    it.from_state = STATE_W'(f);
    it.slot_index = SLOT_W'(s);
    it.slot_valid = v;
    it.symbol     = SYM_W'(sym);
    it.to_state   = STATE_W'(to);
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return mk(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 3),
              1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 15));
  endfunction

  // A load that mostly stays inside the states in use and uses the phase alphabet.
  function automatic in_item_t alpha_load(int n, logic [SYM_W-1:0] alpha [4]);
    int f;
    int to;
    f  = ($urandom_range(99) < 90) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
    to = ($urandom_range(99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
    return mk(CMD_LOAD, f, $urandom_range(0, 3), $urandom_range(99) < 85,
              int'(alpha[$urandom_range(0, 3)]), to);
  endfunction

  // Offers one item, with random idle cycles ahead of it, and returns after its transfer.
  task automatic send_item(input in_item_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      in_item_i  <= noise_item();
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
    if (it.cmd != CMD_RESERVED) items_sent++;
  endtask

  // The register is only written once the block has drained.
  task automatic write_states(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_states(v);
    cfg_writes++;
  endtask

  task automatic run_phase(input int budget);
    logic [SYM_W-1:0] alpha [4];
    int n;
    int sent;
    int r;
    int len;
    n = sb.used_states();
    sent = 0;
    foreach (alpha[i]) alpha[i] = SYM_W'($urandom_range(0, 255));
    repeat (2 * n) begin
      send_item(alpha_load(n, alpha));
      sent++;
    end
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(noise_item());
        sent++;
      end else if (r < 18) begin
        send_item(alpha_load(n, alpha));
        sent++;
      end else if (r < 22) begin
        send_item(mk(CMD_FEED, 0, 0, 0, $urandom_range(0, 255), 0));
        sent++;
      end else begin
        // A well-formed string over the phase alphabet.
        send_item(mk(CMD_START, $urandom_range(0, 15), $urandom_range(0, 3), 0,
                     $urandom_range(0, 255), $urandom_range(0, 15)));
        len = $urandom_range(1, 10);
        repeat (len) send_item(mk(CMD_FEED, 0, 0, 0, int'(alpha[$urandom_range(0, 3)]), 0));
        sent += len + 1;
      end
    end
  endtask

  initial begin : main
    logic [CFG_W-1:0] settings [8];
    int drain;
    sb = new();
    settings = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd8, 5'd1, 5'd16, 5'd2};
    settings[7] = CFG_W'($urandom_range(2, 15));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table straight out of reset, then a restart with one state in use.
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));
    send_item(mk(CMD_START, 0, 0, 0, 0, 0));

    write_states(5'd4);
    send_item(mk(CMD_LOAD, 0, 0, 1, 8'h00, 1));
    send_item(mk(CMD_LOAD, 1, 3, 1, 8'hFF, 3));
    send_item(mk(CMD_LOAD, 0, 1, 1, 8'h00, 2));
    send_item(mk(CMD_LOAD, 2, 2, 1, 8'hFF, 9));
    send_item(mk(CMD_LOAD, 15, 3, 1, 8'hA5, 15));
    send_item(mk(CMD_LOAD, 3, 0, 0, 8'h5A, 0));
    send_item(mk(CMD_RESERVED, 15, 3, 1, 8'hFF, 15));
    send_item(mk(CMD_START, 0, 0, 0, 0, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'hFF, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h5A, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));
    send_item(mk(CMD_START, 0, 0, 0, 0, 0));
    // Load in the middle of a string, seen by the next symbol.
    send_item(mk(CMD_LOAD, 0, 0, 1, 8'h11, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h11, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));

    // Widen the range mid-string so state 9 becomes reachable, then shrink it again.
    write_states(5'd16);
    send_item(mk(CMD_FEED, 0, 0, 0, 8'hFF, 0));
    write_states(5'd4);
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));

    write_states(5'd0);
    send_item(mk(CMD_START, 0, 0, 0, 0, 0));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h11, 0));

    write_states(5'd31);
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));
    send_item(mk(CMD_LOAD, 2, 0, 1, 8'h00, 15));
    send_item(mk(CMD_FEED, 0, 0, 0, 8'h00, 0));

    for (int p = 0; p < 8; p++) begin
      write_states(settings[p]);
      hold_req = (p == 1);
      quiet    = (p == 5);
      run_phase(200);
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("Sent %0d items under %0d register settings; %0d verdicts compared.",
             items_sent, cfg_writes, sb.checked);
    $display("Traffic included random stalls, a %0d-cycle output hold-off and a gap-free phase.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[nfa_string_recognizer.f]
+incdir+design
design/nfasr_pkg.sv
design/nfasr_slot_table.sv
design/nfasr_next_state.sv
design/nfa_string_recognizer.sv
tb/sv/tb_top.sv
